@@ rtl/analog_keypad_majority_decoder_unit_assert.svh @@
// assertion macros for the analog keypad majority decoder
`ifndef ANALOG_KEYPAD_MAJORITY_DECODER_UNIT_ASSERT_SVH
`define ANALOG_KEYPAD_MAJORITY_DECODER_UNIT_ASSERT_SVH

// implication in the same cycle
`define AKMD_ASSERT_SAME(label, clk, rst, pre, post) \
   label: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) \
      else $error("akmd assertion failed");

// implication on the following cycle
`define AKMD_ASSERT_NEXT(label, clk, rst, pre, post) \
   label: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) \
      else $error("akmd assertion failed");

`endif

@@ rtl/akmd_pkg.sv @@
// shared types and constants of the analog keypad majority decoder
`timescale 1ns / 1ps

package akmd_pkg;

   typedef logic [2:0] key_type;

   localparam key_type BTN_NONE   = 3'd0;
   localparam key_type BTN_UP     = 3'd1;
   localparam key_type BTN_DOWN   = 3'd2;
   localparam key_type BTN_LEFT   = 3'd3;
   localparam key_type BTN_RIGHT  = 3'd4;
   localparam key_type BTN_MIDDLE = 3'd5;

   localparam int SAMPLE_BITS = 12;
   localparam int TIME_BITS   = 32;
   localparam int WINDOW_BITS = 16;

   localparam logic CSR_WINDOW_MS     = 1'b0;
   localparam logic CSR_LAYOUT_SELECT = 1'b1;

   // one classified sample in flight between front and back
   typedef struct packed {
      logic                 hit;
      key_type              key;
      logic [TIME_BITS-1:0] now_ms;
   } q_entry_type;

   typedef struct packed {
      logic full;
      logic empty;
   } q_status_type;

endpackage

@@ rtl/akmd_front.sv @@
// front end: takes samples and maps them to keys through the voltage windows
`timescale 1ns / 1ps

module akmd_front (
   input  logic                                  req_valid,
   output logic                                  req_ready,
   input  logic [akmd_pkg::SAMPLE_BITS-1:0]      req_sample,
   input  logic [akmd_pkg::TIME_BITS-1:0]        req_now_ms,
   input  logic                                  layout_select,
   input  akmd_pkg::q_status_type                q_status,
   output logic                                  push,
   output akmd_pkg::q_entry_type                 push_entry
);

   localparam logic [11:0] DEF_NONE_LO   = 12'd4000;
   localparam logic [11:0] DEF_LEFT_LO   = 12'd2000;
   localparam logic [11:0] DEF_LEFT_HI   = 12'd2500;
   localparam logic [11:0] EDGE_HI       = 12'd300;
   localparam logic [11:0] MID_BAND_LO   = 12'd2600;
   localparam logic [11:0] MID_BAND_HI   = 12'd3000;
   localparam logic [11:0] DEF_UP_LO     = 12'd1000;
   localparam logic [11:0] DEF_UP_HI     = 12'd1600;
   localparam logic [11:0] TOP_BAND_LO   = 12'd3200;
   localparam logic [11:0] TOP_BAND_HI   = 12'd3400;
   localparam logic [11:0] ALT_NONE_LO   = 12'd3900;
   localparam logic [11:0] ALT_RIGHT_LO  = 12'd2300;
   localparam logic [11:0] ALT_DOWN_LO   = 12'd1200;
   localparam logic [11:0] ALT_DOWN_HI   = 12'd1700;

   logic              hit;
   akmd_pkg::key_type key;

   // windows tested in priority order, a miss keeps the previous key downstream
   always_comb begin
      hit = 1'b1;
      key = akmd_pkg::BTN_NONE;
      if (layout_select) begin
         if (req_sample > ALT_NONE_LO) begin
            key = akmd_pkg::BTN_NONE;
         end else if (req_sample > ALT_RIGHT_LO && req_sample < DEF_LEFT_HI) begin
            key = akmd_pkg::BTN_RIGHT;
         end else if (req_sample < EDGE_HI) begin
            key = akmd_pkg::BTN_LEFT;
         end else if (req_sample > MID_BAND_LO && req_sample < MID_BAND_HI) begin
            key = akmd_pkg::BTN_UP;
         end else if (req_sample > ALT_DOWN_LO && req_sample < ALT_DOWN_HI) begin
            key = akmd_pkg::BTN_DOWN;
         end else if (req_sample > TOP_BAND_LO && req_sample < TOP_BAND_HI) begin
            key = akmd_pkg::BTN_MIDDLE;
         end else begin
            hit = 1'b0;
         end
      end else begin
         if (req_sample > DEF_NONE_LO) begin
            key = akmd_pkg::BTN_NONE;
         end else if (req_sample > DEF_LEFT_LO && req_sample < DEF_LEFT_HI) begin
            key = akmd_pkg::BTN_LEFT;
         end else if (req_sample < EDGE_HI) begin
            key = akmd_pkg::BTN_RIGHT;
         end else if (req_sample > MID_BAND_LO && req_sample < MID_BAND_HI) begin
            key = akmd_pkg::BTN_DOWN;
         end else if (req_sample > DEF_UP_LO && req_sample < DEF_UP_HI) begin
            key = akmd_pkg::BTN_UP;
         end else if (req_sample > TOP_BAND_LO && req_sample < TOP_BAND_HI) begin
            key = akmd_pkg::BTN_MIDDLE;
         end else begin
            hit = 1'b0;
         end
      end
   end

   assign req_ready         = !q_status.full;
   assign push              = req_valid && req_ready;
   assign push_entry.hit    = hit;
   assign push_entry.key    = key;
   assign push_entry.now_ms = req_now_ms;

endmodule

@@ rtl/akmd_queue.sv @@
// two-entry queue between the classifier and the counting back end
`timescale 1ns / 1ps
`include "analog_keypad_majority_decoder_unit_assert.svh"

module akmd_queue (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   push,
   input  akmd_pkg::q_entry_type  push_entry,
   input  logic                   pop,
   output akmd_pkg::q_entry_type  head,
   output akmd_pkg::q_status_type q_status
);

   akmd_pkg::q_entry_type mem_ff [2];
   logic                  wr_ptr_ff;
   logic                  wr_ptr_in;
   logic                  rd_ptr_ff;
   logic                  rd_ptr_in;
   logic [1:0]            count_ff;
   logic [1:0]            count_in;

   always_comb begin
      wr_ptr_in = push ? !wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = pop ? !rd_ptr_ff : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !pop) begin
         count_in = count_ff + 2'd1;
      end else if (pop && !push) begin
         count_in = count_ff - 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= push_entry;
      end
   end

   assign head           = mem_ff[rd_ptr_ff];
   assign q_status.full  = count_ff == 2'd2;
   assign q_status.empty = count_ff == 2'd0;

   `AKMD_ASSERT_SAME(a_no_overfill, clock, reset, push && !pop, count_ff != 2'd2)
   `AKMD_ASSERT_SAME(a_no_underrun, clock, reset, pop, count_ff != 2'd0)

endmodule

@@ rtl/akmd_back.sv @@
// back end: per-key counters, window timing and majority decision
`timescale 1ns / 1ps
`include "analog_keypad_majority_decoder_unit_assert.svh"

module akmd_back #(
   parameter int KEY_COUNT  = 6,
   parameter int COUNT_BITS = 16
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic [akmd_pkg::WINDOW_BITS-1:0]     window_ms,
   input  akmd_pkg::q_entry_type                head,
   input  akmd_pkg::q_status_type               q_status,
   output logic                                 pop,
   output logic                                 rsp_valid,
   input  logic                                 rsp_ready,
   output akmd_pkg::key_type                    rsp_key_code
);

   logic [COUNT_BITS-1:0]          counts_ff  [KEY_COUNT];
   logic [COUNT_BITS-1:0]          counts_inc [KEY_COUNT];
   akmd_pkg::key_type              raw_key_ff;
   akmd_pkg::key_type              raw_key_in;
   logic [akmd_pkg::TIME_BITS-1:0] window_start_ff;
   akmd_pkg::key_type              last_ff;
   logic                           rsp_valid_ff;
   logic                           rsp_valid_in;
   akmd_pkg::key_type              rsp_key_ff;
   logic [akmd_pkg::TIME_BITS-1:0] elapsed;
   logic                           decide;
   logic [COUNT_BITS-1:0]          best;
   akmd_pkg::key_type              pick;
   logic                           emit;

   assign pop        = !q_status.empty && (!rsp_valid_ff || rsp_ready);
   assign raw_key_in = head.hit ? head.key : raw_key_ff;
   assign elapsed    = head.now_ms - window_start_ff;
   assign decide     = elapsed > akmd_pkg::TIME_BITS'(window_ms);

   // saturating count of the current key
   always_comb begin
      for (int i = 0; i < KEY_COUNT; i++) begin
         counts_inc[i] = counts_ff[i];
         if (raw_key_in == 3'(i) && counts_ff[i] != '1) begin
            counts_inc[i] = counts_ff[i] + COUNT_BITS'(1);
         end
      end
   end

   // highest count wins, lowest code on ties, none when all are zero
   always_comb begin
      best = '0;
      pick = akmd_pkg::BTN_NONE;
      for (int i = 0; i < KEY_COUNT; i++) begin
         if (counts_inc[i] > best) begin
            best = counts_inc[i];
            pick = 3'(i);
         end
      end
   end

   assign emit = decide && (pick != akmd_pkg::BTN_NONE || last_ff != akmd_pkg::BTN_NONE);

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (pop) begin
         rsp_valid_in = emit;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         raw_key_ff      <= akmd_pkg::BTN_NONE;
         window_start_ff <= '0;
         last_ff         <= akmd_pkg::BTN_NONE;
         rsp_valid_ff    <= 1'b0;
         for (int i = 0; i < KEY_COUNT; i++) begin
            counts_ff[i] <= '0;
         end
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         if (pop) begin
            raw_key_ff <= raw_key_in;
            if (decide) begin
               window_start_ff <= head.now_ms;
               last_ff         <= pick;
               for (int i = 0; i < KEY_COUNT; i++) begin
                  counts_ff[i] <= '0;
               end
            end else begin
               for (int i = 0; i < KEY_COUNT; i++) begin
                  counts_ff[i] <= counts_inc[i];
               end
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (pop && emit) begin
         rsp_key_ff <= pick;
      end
   end

   assign rsp_valid    = rsp_valid_ff;
   assign rsp_key_code = rsp_key_ff;

   `AKMD_ASSERT_NEXT(a_clear_after_pick, clock, reset, pop && decide, counts_ff[0] == '0)
   `AKMD_ASSERT_SAME(a_key_in_range, clock, reset, rsp_valid_ff, {1'b0, rsp_key_ff} < 4'(KEY_COUNT))
   `AKMD_ASSERT_NEXT(a_pick_recorded, clock, reset, pop && emit, last_ff == rsp_key_ff)

endmodule

@@ rtl/analog_keypad_majority_decoder_unit.sv @@
// top level of the analog keypad majority decoder
//
//  channel  direction  handshake              payload
//  req      in         req_valid / req_ready  req_sample[11:0], req_now_ms[31:0]
//  rsp      out        rsp_valid / rsp_ready  rsp_key_code[2:0]
//  csr      in         csr_we                 csr_index[0], csr_wdata[15:0]
//
// one sample per cycle sustained while rsp is not stalled; a req transfer is written into the
// two-entry queue, the back end pops it from there and registers its decision in rsp_valid
// the back end's count, elapsed-time compare and six-way pick are all combinational
// synchronous active-high reset clears queue, counters, window start and last pick
// a stalled rsp holds the back end; the queue then fills and req_ready drops
`timescale 1ns / 1ps

module analog_keypad_majority_decoder_unit #(
   parameter int KEY_COUNT  = 6,
   parameter int COUNT_BITS = 16
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_valid,
   output logic                                 req_ready,
   input  logic [akmd_pkg::SAMPLE_BITS-1:0]     req_sample,
   input  logic [akmd_pkg::TIME_BITS-1:0]       req_now_ms,
   output logic                                 rsp_valid,
   input  logic                                 rsp_ready,
   output logic [2:0]                           rsp_key_code,
   input  logic                                 csr_we,
   input  logic                                 csr_index,
   input  logic [akmd_pkg::WINDOW_BITS-1:0]     csr_wdata
);

   logic [akmd_pkg::WINDOW_BITS-1:0] window_ms_ff;
   logic                             layout_ff;
   akmd_pkg::q_status_type           q_status;
   akmd_pkg::q_entry_type            push_entry;
   akmd_pkg::q_entry_type            head;
   logic                             push;
   logic                             pop;

   always_ff @(posedge clock) begin
      if (reset) begin
         window_ms_ff <= akmd_pkg::WINDOW_BITS'(50);
         layout_ff    <= 1'b0;
      end else if (csr_we) begin
         case (csr_index)
            akmd_pkg::CSR_WINDOW_MS: begin
               window_ms_ff <= csr_wdata;
            end
            akmd_pkg::CSR_LAYOUT_SELECT: begin
               layout_ff <= csr_wdata[0];
            end
            default: begin
               layout_ff <= layout_ff;
            end
         endcase
      end
   end

   akmd_front u_front (
      .req_valid     (req_valid),
      .req_ready     (req_ready),
      .req_sample    (req_sample),
      .req_now_ms    (req_now_ms),
      .layout_select (layout_ff),
      .q_status      (q_status),
      .push          (push),
      .push_entry    (push_entry)
   );

   akmd_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_entry (push_entry),
      .pop        (pop),
      .head       (head),
      .q_status   (q_status)
   );

   akmd_back #(
      .KEY_COUNT  (KEY_COUNT),
      .COUNT_BITS (COUNT_BITS)
   ) u_back (
      .clock        (clock),
      .reset        (reset),
      .window_ms    (window_ms_ff),
      .head         (head),
      .q_status     (q_status),
      .pop          (pop),
      .rsp_valid    (rsp_valid),
      .rsp_ready    (rsp_ready),
      .rsp_key_code (rsp_key_code)
   );

endmodule
